>>> hdl/grdsm_pkg.sv
// Package for the gimbal rate-damped servo mixer.
// Holds widths, register indexes, state and command types; every module imports it.
// Depends on nothing.
package grdsm_pkg;

    localparam int STICK_W = 12;
    localparam int RATE_W  = 16;
    localparam int DT_W    = 16;
    localparam int GAIN_W  = 16;
    localparam int TRIM_W  = 11;
    localparam int LIM_W   = 24;
    localparam int TC_W    = 24;
    localparam int MODE_W  = 3;
    localparam int PULSE_W = 12;
    localparam int LP_W    = 32;
    localparam int ALPHA_W = 16;
    localparam int DEN_W   = TC_W + 1;
    localparam int MA_W    = LP_W + 1;
    localparam int MB_W    = ALPHA_W + 1;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int SUM_W   = 14;
    localparam int V_W     = 51;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [LIM_W-1:0] LIMITS_RESET = 24'h801000;
    localparam logic signed [SUM_W-1:0] REV_CENTER = 14'sd3000;

    localparam int MODE_REV_PAN  = 0;
    localparam int MODE_REV_TILT = 1;
    localparam int MODE_ACTIVE   = 2;

    typedef enum logic [2:0] {
        REG_PAN_GAIN     = 3'd0,
        REG_TILT_GAIN    = 3'd1,
        REG_PAN_OFFSET   = 3'd2,
        REG_TILT_OFFSET  = 3'd3,
        REG_PAN_LIMITS   = 3'd4,
        REG_TILT_LIMITS  = 3'd5,
        REG_WASHOUT_TIME = 3'd6,
        REG_MODE_FLAGS   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [GAIN_W-1:0] pan_gain;
        logic signed [GAIN_W-1:0] tilt_gain;
        logic signed [TRIM_W-1:0] pan_offset;
        logic signed [TRIM_W-1:0] tilt_offset;
        logic [LIM_W-1:0]         pan_limits;
        logic [LIM_W-1:0]         tilt_limits;
        logic [TC_W-1:0]          washout_time;
        logic [MODE_W-1:0]        mode_flags;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_DIV,
        S_LPY,
        S_LPP,
        S_MY,
        S_MP,
        S_VT,
        S_CT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        MUL_LPY,
        MUL_LPP,
        MUL_DY,
        MUL_DP
    } t_mul_sel;

    typedef struct packed {
        logic     load_in;
        logic     div_init;
        logic     div_step;
        t_mul_sel mul_sel;
        logic     lp_y_we;
        logic     lp_p_we;
        logic     v_load;
        logic     v_tilt;
        logic     pan_we;
        logic     tilt_we;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic wash;
        logic out_free;
    } t_status;

endpackage

>>> hdl/grdsm_regs.sv
// Configuration register file behind the APB-style port.
// Depends on grdsm_pkg for the register indexes and the t_cfg struct.
module grdsm_regs import grdsm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pan_gain     <= '0;
            r_cfg.tilt_gain    <= '0;
            r_cfg.pan_offset   <= '0;
            r_cfg.tilt_offset  <= '0;
            r_cfg.pan_limits   <= LIMITS_RESET;
            r_cfg.tilt_limits  <= LIMITS_RESET;
            r_cfg.washout_time <= '0;
            r_cfg.mode_flags   <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_PAN_GAIN:     r_cfg.pan_gain     <= pwdata[GAIN_W-1:0];
                REG_TILT_GAIN:    r_cfg.tilt_gain    <= pwdata[GAIN_W-1:0];
                REG_PAN_OFFSET:   r_cfg.pan_offset   <= pwdata[TRIM_W-1:0];
                REG_TILT_OFFSET:  r_cfg.tilt_offset  <= pwdata[TRIM_W-1:0];
                REG_PAN_LIMITS:   r_cfg.pan_limits   <= pwdata[LIM_W-1:0];
                REG_TILT_LIMITS:  r_cfg.tilt_limits  <= pwdata[LIM_W-1:0];
                REG_WASHOUT_TIME: r_cfg.washout_time <= pwdata[TC_W-1:0];
                REG_MODE_FLAGS:   r_cfg.mode_flags   <= pwdata[MODE_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PAN_GAIN:     prdata = {{(PDATA_W-GAIN_W){1'b0}}, r_cfg.pan_gain};
            REG_TILT_GAIN:    prdata = {{(PDATA_W-GAIN_W){1'b0}}, r_cfg.tilt_gain};
            REG_PAN_OFFSET:   prdata = {{(PDATA_W-TRIM_W){1'b0}}, r_cfg.pan_offset};
            REG_TILT_OFFSET:  prdata = {{(PDATA_W-TRIM_W){1'b0}}, r_cfg.tilt_offset};
            REG_PAN_LIMITS:   prdata = {{(PDATA_W-LIM_W){1'b0}}, r_cfg.pan_limits};
            REG_TILT_LIMITS:  prdata = {{(PDATA_W-LIM_W){1'b0}}, r_cfg.tilt_limits};
            REG_WASHOUT_TIME: prdata = {{(PDATA_W-TC_W){1'b0}}, r_cfg.washout_time};
            REG_MODE_FLAGS:   prdata = {{(PDATA_W-MODE_W){1'b0}}, r_cfg.mode_flags};
        endcase
    end

endmodule

>>> hdl/grdsm_ctrl.sv
// Controller state machine of the mixer: sequences divider, shared multiplier and mix.
// Depends on grdsm_pkg for t_state, t_cmd and t_status.
module grdsm_ctrl import grdsm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    localparam int CNT_W = $clog2(ALPHA_W);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_CHK;
            S_CHK: begin
                n_cnt = '0;
                if (!i_st.active) begin
                    n_state = S_IDLE;
                end else if (i_st.wash) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_MY;
                end
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ALPHA_W - 1)) n_state = S_LPY;
            end
            S_LPY: n_state = S_LPP;
            S_LPP: n_state = S_MY;
            S_MY:  n_state = S_MP;
            S_MP:  n_state = S_VT;
            S_VT:  n_state = S_CT;
            S_CT:  n_state = S_OUT;
            S_OUT: if (i_st.out_free) n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.mul_sel = MUL_DY;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_CHK: o_cmd.div_init = 1'b1;
            S_DIV: o_cmd.div_step = 1'b1;
            S_LPY: o_cmd.mul_sel  = MUL_LPY;
            S_LPP: begin
                o_cmd.lp_y_we = 1'b1;
                o_cmd.mul_sel = MUL_LPP;
            end
            S_MY: begin
                o_cmd.lp_p_we = i_st.wash;
                o_cmd.mul_sel = MUL_DY;
            end
            S_MP: begin
                o_cmd.v_load  = 1'b1;
                o_cmd.mul_sel = MUL_DP;
            end
            S_VT: begin
                o_cmd.pan_we = 1'b1;
                o_cmd.v_load = 1'b1;
                o_cmd.v_tilt = 1'b1;
            end
            S_CT:  o_cmd.tilt_we  = 1'b1;
            S_OUT: o_cmd.out_load = i_st.out_free;
        endcase
    end

    a_accept_to_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE && i_in_valid |=> r_state == S_CHK)
        else $error("accepted word did not enter the check state");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV && r_cnt == CNT_W'(ALPHA_W - 1) |=> r_state == S_LPY)
        else $error("divider did not finish after its last step");

    a_no_lp_without_wash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.lp_y_we || o_cmd.lp_p_we) |-> i_st.wash && i_st.active)
        else $error("low-pass written with washout off");

endmodule

>>> hdl/grdsm_dp.sv
// Datapath of the mixer: input capture, alpha divider, shared multiplier,
// low-pass state, mix, clamp and round, and the output register. Depends on grdsm_pkg.
module grdsm_dp import grdsm_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  t_cmd                      i_cmd,
    output t_status                   o_st,
    input  logic [STICK_W-1:0]        i_pan_stick,
    input  logic [STICK_W-1:0]        i_tilt_stick,
    input  logic signed [RATE_W-1:0]  i_yaw_rate,
    input  logic signed [RATE_W-1:0]  i_pitch_rate,
    input  logic [DT_W-1:0]           i_step_time,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [PULSE_W-1:0]        o_pan_pulse,
    output logic [PULSE_W-1:0]        o_tilt_pulse
);

    logic [STICK_W-1:0]       r_pan_stick, r_tilt_stick;
    logic signed [RATE_W-1:0] r_yaw, r_pitch;
    logic [DT_W-1:0]          r_dt;
    logic                     r_wash;

    logic [DEN_W-1:0]   r_rem, r_den;
    logic [ALPHA_W-1:0] r_q;
    logic [DEN_W:0]     div_t;
    logic               div_ge;

    logic signed [LP_W-1:0]   r_lp_y, r_lp_p;
    logic signed [MA_W-1:0]   yaw_q, pitch_q, d_y, d_p, mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] mul_p, r_prod;

    logic [STICK_W-1:0]       vf_stick;
    logic                     vf_rev;
    logic signed [TRIM_W-1:0] vf_trim;
    logic signed [SUM_W-1:0]  vf_base, vf_sum;
    logic signed [V_W-1:0]    vf_hi, vf_p, vf_v, r_v;

    logic [LIM_W-1:0]      cl_lim;
    logic signed [V_W-1:0] cl_lo, cl_hi, cl_v, cl_rnd;
    logic [PULSE_W-1:0]    cl_pulse;

    logic [PULSE_W-1:0] r_pan_res, r_tilt_res, r_o_pan, r_o_tilt;
    logic               r_out_valid;

    // Input capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wash <= 1'b0;
        end else if (i_cmd.load_in) begin
            r_wash <= (i_cfg.washout_time != '0) && (i_step_time != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_pan_stick  <= i_pan_stick;
            r_tilt_stick <= i_tilt_stick;
            r_yaw        <= i_yaw_rate;
            r_pitch      <= i_pitch_rate;
            r_dt         <= i_step_time;
        end
    end

    // Restoring divider for alpha = dt * 2^16 / (tc + dt). Since tc is nonzero
    // here, dt lies below the divisor and only the sixteen fraction bits remain.
    assign div_t  = {r_rem, 1'b0};
    assign div_ge = div_t >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= {{(DEN_W-DT_W){1'b0}}, r_dt};
            r_den <= {1'b0, i_cfg.washout_time} + {{(DEN_W-DT_W){1'b0}}, r_dt};
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? DEN_W'(div_t - {1'b0, r_den}) : div_t[DEN_W-1:0];
            r_q   <= {r_q[ALPHA_W-2:0], div_ge};
        end
    end

    // Rates in Q16 and the damping terms.
    assign yaw_q   = {r_yaw[RATE_W-1], r_yaw, 16'b0};
    assign pitch_q = {r_pitch[RATE_W-1], r_pitch, 16'b0};
    assign d_y     = r_wash ? yaw_q - {r_lp_y[LP_W-1], r_lp_y} : yaw_q;
    assign d_p     = r_wash ? pitch_q - {r_lp_p[LP_W-1], r_lp_p} : pitch_q;

    // Shared multiplier with a registered product.
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_LPY: begin
                mul_a = d_y;
                mul_b = {1'b0, r_q};
            end
            MUL_LPP: begin
                mul_a = d_p;
                mul_b = {1'b0, r_q};
            end
            MUL_DY: begin
                mul_a = d_y;
                mul_b = {i_cfg.pan_gain[GAIN_W-1], i_cfg.pan_gain};
            end
            default: begin
                mul_a = d_p;
                mul_b = {i_cfg.tilt_gain[GAIN_W-1], i_cfg.tilt_gain};
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
    end

    // Low-pass state: the floor shift by 16 keeps only bits 47..16 once the
    // sum is cut back to 32 bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp_y <= '0;
            r_lp_p <= '0;
        end else begin
            if (i_cmd.lp_y_we) r_lp_y <= r_lp_y + r_prod[LP_W+15:16];
            if (i_cmd.lp_p_we) r_lp_p <= r_lp_p + r_prod[LP_W+15:16];
        end
    end

    // Mix in Q32 microseconds.
    assign vf_stick = i_cmd.v_tilt ? r_tilt_stick : r_pan_stick;
    assign vf_rev   = i_cmd.v_tilt ? i_cfg.mode_flags[MODE_REV_TILT]
                                   : i_cfg.mode_flags[MODE_REV_PAN];
    assign vf_trim  = i_cmd.v_tilt ? i_cfg.tilt_offset : i_cfg.pan_offset;
    assign vf_base  = vf_rev ? REV_CENTER - $signed({2'b0, vf_stick})
                             : $signed({2'b0, vf_stick});
    assign vf_sum   = vf_base + {{(SUM_W-TRIM_W){vf_trim[TRIM_W-1]}}, vf_trim};
    assign vf_hi    = $signed({{(V_W-SUM_W-32){vf_sum[SUM_W-1]}}, vf_sum, 32'b0});
    assign vf_p     = {{(V_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign vf_v     = vf_rev ? vf_hi + vf_p : vf_hi - vf_p;

    always_ff @(posedge i_clk) begin
        if (i_cmd.v_load) r_v <= vf_v;
    end

    // Clamp to the minimum first, then the maximum, then round half up.
    assign cl_lim   = i_cmd.tilt_we ? i_cfg.tilt_limits : i_cfg.pan_limits;
    assign cl_lo    = $signed({{(V_W-PULSE_W-32){1'b0}}, cl_lim[11:0], 32'b0});
    assign cl_hi    = $signed({{(V_W-PULSE_W-32){1'b0}}, cl_lim[23:12], 32'b0});
    assign cl_v     = (r_v < cl_lo) ? cl_lo : ((r_v > cl_hi) ? cl_hi : r_v);
    assign cl_rnd   = cl_v + $signed({{(V_W-32){1'b0}}, 1'b1, 31'b0});
    assign cl_pulse = cl_rnd[PULSE_W+31:32];

    always_ff @(posedge i_clk) begin
        if (i_cmd.pan_we)  r_pan_res  <= cl_pulse;
        if (i_cmd.tilt_we) r_tilt_res <= cl_pulse;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_pan  <= r_pan_res;
            r_o_tilt <= r_tilt_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pan_pulse  = r_o_pan;
    assign o_tilt_pulse = r_o_tilt;

    assign o_st.active   = i_cfg.mode_flags[MODE_ACTIVE];
    assign o_st.wash     = r_wash;
    assign o_st.out_free = !r_out_valid || i_out_ready;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid || i_out_ready)
        else $error("output register overwritten while a word waits");

    a_lp_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_wash |=> $stable(r_lp_y) && $stable(r_lp_p))
        else $error("low-pass state changed with washout off");

endmodule

>>> hdl/gimbal_rate_damped_servo_mix.sv
// Two-axis gimbal servo mixer with rate damping and washout.
// Input channel (i_in_valid / o_in_ready) carries one word per control tick:
// both stick pulses, yaw and pitch rates and the step time. Output channel
// (o_out_valid / i_out_ready) carries the pan and tilt pulses of that tick.
// Configuration is written through the APB-style port; the user must write it
// only while idle, as the block does not enforce this. One word is worked on at
// a time: a new word is taken only once the last is loaded into the output
// register. With washout active a word passes the 16-step alpha divider and
// goes four times through the shared multiplier, else twice. With the active
// bit clear a word is taken and dropped, leaving the low-pass state unchanged.
// The result sits in an output register, so while the receiver stalls the
// next word is accepted and computed, and waits only for its final load.
// Synchronous reset clears the registers to their defaults, both low-pass
// states to zero and the output channel to empty.
// Depends on grdsm_pkg, grdsm_regs, grdsm_ctrl and grdsm_dp.
module gimbal_rate_damped_servo_mix import grdsm_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [STICK_W-1:0]        i_pan_stick,
    input  logic [STICK_W-1:0]        i_tilt_stick,
    input  logic signed [RATE_W-1:0]  i_yaw_rate,
    input  logic signed [RATE_W-1:0]  i_pitch_rate,
    input  logic [DT_W-1:0]           i_step_time,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [PULSE_W-1:0]        o_pan_pulse,
    output logic [PULSE_W-1:0]        o_tilt_pulse
);

    t_cfg    cfg;
    t_cmd    cmd;
    t_status st;

    grdsm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    grdsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    grdsm_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_cmd        (cmd),
        .o_st         (st),
        .i_pan_stick  (i_pan_stick),
        .i_tilt_stick (i_tilt_stick),
        .i_yaw_rate   (i_yaw_rate),
        .i_pitch_rate (i_pitch_rate),
        .i_step_time  (i_step_time),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pan_pulse  (o_pan_pulse),
        .o_tilt_pulse (o_tilt_pulse)
    );

endmodule
